>>> src/clsc_pkg.sv
// shared types, constants and helpers for the calendar loaded seconds clock
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package clsc_pkg;

    // command codes on the input tuser
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_LOAD_DATE = 2'd1;
    localparam logic [1:0] CMD_LOAD_RAW = 2'd2;

    localparam int          SECONDS_WIDTH_DEFAULT = 32;
    localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

    localparam logic [11:0] YEAR_BASE        = 12'd1970;
    localparam logic [19:0] DAYS_PER_YEAR    = 20'd365;
    localparam logic [10:0] LEAPS_TO_BASE    = 11'd477;
    localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECONDS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECONDS_PER_MIN  = 17'd60;
    localparam logic [11:0] YEARS_PER_CENTURY = 12'd100;
    localparam logic [11:0] YEARS_PER_ERA    = 12'd400;
    // 2^22 / 100 rounded up, exact for any 12 bit dividend
    localparam logic [15:0] RECIP_100        = 16'd41944;

    // what the back end does with a queued item
    typedef enum logic [1:0] {
        OP_NOP,
        OP_TICK,
        OP_DATE,
        OP_RAW
    } op_t;

    function automatic logic [5:0] div100(input logic [11:0] n);
        logic [27:0] prod;
        begin
            prod = 28'(n) * 28'(RECIP_100);
            return prod[27:22];
        end
    endfunction

    // days before the first of each month in a common year
    function automatic logic [8:0] month_start_days(input logic [3:0] midx);
        logic [8:0] d;
        begin
            case (midx)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                default: d = 9'd334;
            endcase
            return d;
        end
    endfunction

endpackage

>>> src/calendar_loaded_seconds_clock.sv
// throughput: one item per cycle while each result is taken; the front pipeline,
// the queue and the counter update each handle one item a cycle unless stalled
// reset: asynchronous, clears all counters, empties the pipeline and queue,
// and sets ticks_per_second to 1000
// top level of the seconds clock; depends on clsc_pkg, clsc_front,
// clsc_queue and clsc_back
`timescale 1ns / 1ps

module calendar_loaded_seconds_clock #(
    parameter int SECONDS_WIDTH = clsc_pkg::SECONDS_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // ticks_per_second
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
    // month_of_year, calendar_year, raw_seconds, zero fill
    input  logic [71:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,   // cmd, from_primary
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // epoch_seconds, boot_seconds, ticks_in_second
    output logic [79:0] m_axis_tdata
);

    logic [15:0]              tps_reg;
    logic                     push_valid;
    logic                     push_ready;
    clsc_pkg::op_t            push_op;
    logic [SECONDS_WIDTH-1:0] push_value;
    logic                     pop_valid;
    logic                     pop_ready;
    clsc_pkg::op_t            pop_op;
    logic [SECONDS_WIDTH-1:0] pop_value;
    logic [31:0]              epoch_seconds;
    logic [31:0]              boot_seconds;
    logic [15:0]              ticks_in_second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= clsc_pkg::TICKS_PER_SECOND_RESET;
        else if (cfg_we)
            tps_reg <= cfg_wdata;
    end

    clsc_front #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .cmd              (s_axis_tuser[1:0]),
        .from_primary     (s_axis_tuser[2]),
        .second_of_minute (s_axis_tdata[5:0]),
        .minute_of_hour   (s_axis_tdata[11:6]),
        .hour_of_day      (s_axis_tdata[16:12]),
        .day_of_month     (s_axis_tdata[21:17]),
        .month_of_year    (s_axis_tdata[25:22]),
        .calendar_year    (s_axis_tdata[37:26]),
        .raw_seconds      (s_axis_tdata[69:38]),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_op          (push_op),
        .push_value       (push_value)
    );

    clsc_queue #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_value (push_value),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .pop_value  (pop_value)
    );

    clsc_back #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .ticks_per_second (tps_reg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_op           (pop_op),
        .pop_value        (pop_value),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .epoch_seconds    (epoch_seconds),
        .boot_seconds     (boot_seconds),
        .ticks_in_second  (ticks_in_second)
    );

    assign m_axis_tdata = {ticks_in_second, boot_seconds, epoch_seconds};

endmodule

>>> src/clsc_front.sv
// front end: accepts items, classifies them and converts dates to seconds
// four register stages; depends on clsc_pkg
`timescale 1ns / 1ps

module clsc_front #(
    parameter int SECONDS_WIDTH = clsc_pkg::SECONDS_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic                     from_primary,
    input  logic [5:0]               second_of_minute,
    input  logic [5:0]               minute_of_hour,
    input  logic [4:0]               hour_of_day,
    input  logic [4:0]               day_of_month,
    input  logic [3:0]               month_of_year,
    input  logic [11:0]              calendar_year,
    input  logic [31:0]              raw_seconds,
    output logic                     push_valid,
    input  logic                     push_ready,
    output clsc_pkg::op_t            push_op,
    output logic [SECONDS_WIDTH-1:0] push_value
);

    // stage 1: registered input fields
    logic                v1_reg;
    clsc_pkg::op_t       op1_reg;
    logic [5:0]          sec1_reg;
    logic [5:0]          min1_reg;
    logic [4:0]          hour1_reg;
    logic [4:0]          day1_reg;
    logic [3:0]          mon1_reg;
    logic [11:0]         year1_reg;
    logic [31:0]         raw1_reg;

    // stage 2: year days, leap counts, month days, time of day
    logic                v2_reg;
    clsc_pkg::op_t       op2_reg;
    logic [19:0]         ydays2_reg;
    logic [10:0]         leaps2_reg;
    logic                after_base2_reg;
    logic                leap_adj2_reg;
    logic [8:0]          mdays2_reg;
    logic [4:0]          day2_reg;
    logic [16:0]         tod2_reg;
    logic [31:0]         raw2_reg;

    // stage 3: day count including the current day
    logic                v3_reg;
    clsc_pkg::op_t       op3_reg;
    logic [21:0]         days3_reg;
    logic [16:0]         tod3_reg;
    logic [31:0]         raw3_reg;

    // stage 4: day count scaled to seconds
    logic                v4_reg;
    clsc_pkg::op_t       op4_reg;
    logic [38:0]         prod4_reg;
    logic [16:0]         tod4_reg;
    logic [31:0]         raw4_reg;

    logic                en1;
    logic                en2;
    logic                en3;
    logic                en4;
    clsc_pkg::op_t       op_in;

    logic [11:0]         yr_m1;
    logic [11:0]         yr_diff;
    logic [9:0]          q4a;
    logic [5:0]          q100a;
    logic [5:0]          q400a;
    logic [5:0]          q100b;
    logic [5:0]          q400b;
    logic                is_leap;
    logic [3:0]          midx;
    logic [16:0]         tod;
    logic [21:0]         days;
    logic [63:0]         date_sum;

    assign en4      = !v4_reg || push_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        unique case (cmd)
            clsc_pkg::CMD_TICK:      op_in = from_primary ? clsc_pkg::OP_TICK : clsc_pkg::OP_NOP;
            clsc_pkg::CMD_LOAD_DATE: op_in = clsc_pkg::OP_DATE;
            clsc_pkg::CMD_LOAD_RAW:  op_in = clsc_pkg::OP_RAW;
            default:                 op_in = clsc_pkg::OP_NOP;
        endcase
    end

    // stage 2 logic
    always_comb
    begin
        yr_m1   = year1_reg - 12'd1;
        yr_diff = year1_reg - clsc_pkg::YEAR_BASE;
        q4a     = yr_m1[11:2];
        q100a   = clsc_pkg::div100(yr_m1);
        q400a   = clsc_pkg::div100({2'b00, q4a});
        q100b   = clsc_pkg::div100(year1_reg);
        q400b   = clsc_pkg::div100({2'b00, year1_reg[11:2]});
        is_leap = (year1_reg[1:0] == 2'b00)
               && ((12'(q100b) * clsc_pkg::YEARS_PER_CENTURY != year1_reg)
               ||  (12'(q400b) * clsc_pkg::YEARS_PER_ERA == year1_reg));
        if (mon1_reg == 4'd0)
            midx = 4'd0;
        else if (mon1_reg > 4'd12)
            midx = 4'd11;
        else
            midx = mon1_reg - 4'd1;
        tod = 17'(hour1_reg) * clsc_pkg::SECONDS_PER_HOUR
            + 17'(min1_reg) * clsc_pkg::SECONDS_PER_MIN
            + 17'(sec1_reg);
    end

    // stage 3 logic: one based day leaves the count one high, taken back below
    always_comb
    begin
        days = 22'(ydays2_reg) + 22'(mdays2_reg) + 22'(day2_reg) + 22'(leap_adj2_reg);
        if (after_base2_reg)
            days = days + 22'(leaps2_reg) - 22'(clsc_pkg::LEAPS_TO_BASE);
    end

    assign date_sum   = 64'(prod4_reg) + 64'(tod4_reg) - 64'(clsc_pkg::SECONDS_PER_DAY);
    assign push_valid = v4_reg;
    assign push_op    = op4_reg;
    assign push_value = (op4_reg == clsc_pkg::OP_DATE) ? date_sum[SECONDS_WIDTH-1:0]
                                                       : SECONDS_WIDTH'(raw4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= op_in;
            sec1_reg  <= second_of_minute;
            min1_reg  <= minute_of_hour;
            hour1_reg <= hour_of_day;
            day1_reg  <= day_of_month;
            mon1_reg  <= month_of_year;
            year1_reg <= calendar_year;
            raw1_reg  <= raw_seconds;
        end
        if (en2)
        begin
            op2_reg         <= op1_reg;
            ydays2_reg      <= (year1_reg > clsc_pkg::YEAR_BASE)
                             ? 20'(yr_diff) * clsc_pkg::DAYS_PER_YEAR : 20'd0;
            leaps2_reg      <= 11'(q4a) - 11'(q100a) + 11'(q400a);
            after_base2_reg <= year1_reg > clsc_pkg::YEAR_BASE;
            leap_adj2_reg   <= is_leap && (midx >= 4'd2);
            mdays2_reg      <= clsc_pkg::month_start_days(midx);
            day2_reg        <= day1_reg;
            tod2_reg        <= tod;
            raw2_reg        <= raw1_reg;
        end
        if (en3)
        begin
            op3_reg   <= op2_reg;
            days3_reg <= days;
            tod3_reg  <= tod2_reg;
            raw3_reg  <= raw2_reg;
        end
        if (en4)
        begin
            op4_reg   <= op3_reg;
            prod4_reg <= 39'(days3_reg) * 39'(clsc_pkg::SECONDS_PER_DAY);
            tod4_reg  <= tod3_reg;
            raw4_reg  <= raw3_reg;
        end
    end

endmodule

>>> src/clsc_queue.sv
// short queue between the front and back ends of the seconds clock
// four entries of operation and value; depends on clsc_pkg
`timescale 1ns / 1ps

module clsc_queue #(
    parameter int SECONDS_WIDTH = clsc_pkg::SECONDS_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  clsc_pkg::op_t            push_op,
    input  logic [SECONDS_WIDTH-1:0] push_value,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output clsc_pkg::op_t            pop_op,
    output logic [SECONDS_WIDTH-1:0] pop_value
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    clsc_pkg::op_t            op_mem [DEPTH];
    logic [SECONDS_WIDTH-1:0] value_mem [DEPTH];
    logic [PTR_W-1:0]         head_reg;
    logic [PTR_W-1:0]         tail_reg;
    logic [PTR_W:0]           count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign push_ready = count_reg != (PTR_W + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_op     = op_mem[head_reg];
    assign pop_value  = value_mem[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                tail_reg <= tail_reg + 1'b1;
            if (do_pop)
                head_reg <= head_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_mem[tail_reg]    <= push_op;
            value_mem[tail_reg] <= push_value;
        end
    end

endmodule

>>> src/clsc_back.sv
// back end: holds the tick, boot and epoch counters and presents the result
// the counter registers double as the output register; depends on clsc_pkg
`timescale 1ns / 1ps

module clsc_back #(
    parameter int SECONDS_WIDTH = clsc_pkg::SECONDS_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [15:0]              ticks_per_second,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  clsc_pkg::op_t            pop_op,
    input  logic [SECONDS_WIDTH-1:0] pop_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [31:0]              epoch_seconds,
    output logic [31:0]              boot_seconds,
    output logic [15:0]              ticks_in_second
);

    logic                     out_valid_reg;
    logic [15:0]              sub_reg;
    logic [15:0]              sub_next;
    logic [SECONDS_WIDTH-1:0] uptime_reg;
    logic [SECONDS_WIDTH-1:0] uptime_next;
    logic [SECONDS_WIDTH-1:0] wall_reg;
    logic [SECONDS_WIDTH-1:0] wall_next;
    logic [16:0]              tick_count;
    logic                     do_pop;

    // a new item is applied only once the previous result has been taken
    assign pop_ready       = !out_valid_reg || out_ready;
    assign do_pop          = pop_valid && pop_ready;
    assign out_valid       = out_valid_reg;
    assign epoch_seconds   = wall_reg[31:0];
    assign boot_seconds    = uptime_reg[31:0];
    assign ticks_in_second = sub_reg;
    assign tick_count      = 17'(sub_reg) + 17'd1;

    always_comb
    begin
        sub_next    = sub_reg;
        uptime_next = uptime_reg;
        wall_next   = wall_reg;
        case (pop_op) inside
            clsc_pkg::OP_TICK:
            begin
                if (tick_count >= 17'(ticks_per_second))
                begin
                    sub_next    = '0;
                    uptime_next = uptime_reg + 1'b1;
                    wall_next   = wall_reg + 1'b1;
                end
                else
                begin
                    sub_next = tick_count[15:0];
                end
            end
            clsc_pkg::OP_DATE, clsc_pkg::OP_RAW:
            begin
                wall_next = pop_value;
            end
            default:
            begin
                sub_next = sub_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
            uptime_reg    <= '0;
            wall_reg      <= '0;
        end
        else
        begin
            if (pop_ready)
                out_valid_reg <= pop_valid;
            if (do_pop)
            begin
                sub_reg    <= sub_next;
                uptime_reg <= uptime_next;
                wall_reg   <= wall_next;
            end
        end
    end

endmodule
